// ===== hw/rtl/dqe_pkg.sv =====
`timescale 1ns / 1ps

package dqe_pkg;

	localparam int MAX_LABEL   = 63;
	localparam int STORE_DEPTH = 64;
	localparam int ADDR_W      = $clog2(STORE_DEPTH);
	localparam int CNT_W       = ADDR_W;
	localparam int POS_W       = CNT_W + 1;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [1:0] REQ_START  = 2'd0;
	localparam logic [1:0] REQ_CHAR   = 2'd1;
	localparam logic [1:0] REQ_FINISH = 2'd2;

	localparam logic [1:0] CFG_FLAGS = 2'd0;
	localparam logic [1:0] CFG_TYPE  = 2'd1;
	localparam logic [1:0] CFG_CLASS = 2'd2;

	localparam logic [7:0]  DOT_CHAR      = 8'h2E;
	localparam logic [15:0] FLAGS_RESET   = 16'h0100;
	localparam logic [15:0] TYPE_RESET    = 16'h0001;
	localparam logic [15:0] CLASS_RESET   = 16'h0001;
	localparam logic [7:0]  QDCOUNT_LO    = 8'h01;
	localparam logic [POS_W-1:0] HDR_LEN  = POS_W'(12);
	localparam logic [POS_W-1:0] TAIL_LEN = POS_W'(5);

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_OPEN,
		PH_ABANDONED
	} phase_t;

	typedef enum logic [1:0] {
		CMD_HEADER,
		CMD_LABEL,
		CMD_FINISH,
		CMD_ERROR
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t        kind;
		logic             has_label;
		logic [CNT_W-1:0] count;
		logic [15:0]      id;
	} cmd_t;

	typedef struct packed {
		logic [15:0] flags;
		logic [15:0] qtype;
		logic [15:0] qclass;
	} cfg_t;

	typedef struct packed {
		logic              is_store;
		logic [ADDR_W-1:0] addr;
		logic [7:0]        value;
	} src_t;

	function automatic logic [POS_W-1:0] label_len(cmd_t c);
		logic [POS_W-1:0] n;
		n = '0;
		if (c.kind == CMD_LABEL || (c.kind == CMD_FINISH && c.has_label))
			n = {1'b0, c.count} + POS_W'(1);
		return n;
	endfunction

	function automatic logic [POS_W-1:0] cmd_len(cmd_t c);
		logic [POS_W-1:0] n;
		case (c.kind)
			CMD_HEADER: n = HDR_LEN;
			CMD_LABEL:  n = label_len(c);
			CMD_FINISH: n = label_len(c) + TAIL_LEN;
			default:    n = POS_W'(1);
		endcase
		return n;
	endfunction

	function automatic src_t byte_src(cmd_t c, cfg_t g, logic [POS_W-1:0] p);
		src_t s;
		logic [POS_W-1:0] ll;
		logic [POS_W-1:0] pm1;
		logic [POS_W-1:0] t;
		s   = '0;
		ll  = label_len(c);
		pm1 = p - POS_W'(1);
		t   = p - ll;
		case (c.kind)
			CMD_HEADER: begin
				case (p)
					POS_W'(0): s.value = c.id[15:8];
					POS_W'(1): s.value = c.id[7:0];
					POS_W'(2): s.value = g.flags[15:8];
					POS_W'(3): s.value = g.flags[7:0];
					POS_W'(5): s.value = QDCOUNT_LO;
					default:   s.value = 8'h00;
				endcase
			end
			CMD_LABEL, CMD_FINISH: begin
				if (p < ll) begin
					if (p == '0) begin
						s.value = 8'({1'b0, c.count});
					end else begin
						s.is_store = 1'b1;
						s.addr     = pm1[ADDR_W-1:0];
					end
				end else begin
					case (t)
						POS_W'(1): s.value = g.qtype[15:8];
						POS_W'(2): s.value = g.qtype[7:0];
						POS_W'(3): s.value = g.qclass[15:8];
						POS_W'(4): s.value = g.qclass[7:0];
						default:   s.value = 8'h00;
					endcase
				end
			end
			default: s = '0;
		endcase
		return s;
	endfunction

endpackage

// ===== hw/rtl/dns_query_name_encoder_top.sv =====
`timescale 1ns / 1ps

// DNS query builder: start, name-character and finish items go in, the question
// message comes out up to two bytes per beat with last_of_run on the final beat
// of each command. A front end takes one item per cycle while not stalled, tracks
// the open query and writes name characters into a 64-entry label store; a
// two-entry command queue feeds a back end that loads each command into a register
// and then emits one beat per cycle while the output does not stall; a start
// yields 6 beats. After a '.' or a finish with a pending label the input stalls
// until the back end has read that label out of the store; plain characters are
// taken at one per cycle while the queue has room and no label read is pending.
// The store needs no clearing after reset.
module dns_query_name_encoder_top
	import dqe_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  req_type,
	input  logic [7:0]  name_char,
	input  logic [15:0] query_id,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  byte_first,
	output logic [7:0]  byte_second,
	output logic [1:0]  bytes_valid,
	output logic        last_of_run,
	output logic        status,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	cfg_t              cfg_q;
	logic              cmd_push;
	cmd_t              cmd_data;
	logic              q_full;
	logic              q_pop;
	logic              q_valid;
	cmd_t              q_data;
	logic              store_we;
	logic [ADDR_W-1:0] store_waddr;
	logic [7:0]        store_wdata;
	logic              store_done;
	logic              rd_en;
	logic [ADDR_W-1:0] raddr_a, raddr_b;
	logic [7:0]        rdata_a, rdata_b;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.flags  <= FLAGS_RESET;
			cfg_q.qtype  <= TYPE_RESET;
			cfg_q.qclass <= CLASS_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_FLAGS: cfg_q.flags  <= cfg_data;
				CFG_TYPE:  cfg_q.qtype  <= cfg_data;
				CFG_CLASS: cfg_q.qclass <= cfg_data;
				default:   cfg_q        <= cfg_q;
			endcase
		end
	end

	dqe_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.req_type    (req_type),
		.name_char   (name_char),
		.query_id    (query_id),
		.cmd_push    (cmd_push),
		.cmd_data    (cmd_data),
		.q_full      (q_full),
		.store_we    (store_we),
		.store_waddr (store_waddr),
		.store_wdata (store_wdata),
		.store_done  (store_done)
	);

	dqe_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (cmd_push),
		.push_data (cmd_data),
		.full      (q_full),
		.pop       (q_pop),
		.valid     (q_valid),
		.pop_data  (q_data)
	);

	dqe_ram #(
		.WIDTH (8),
		.DEPTH (STORE_DEPTH)
	) u_store (
		.clk     (clk),
		.we      (store_we),
		.waddr   (store_waddr),
		.wdata   (store_wdata),
		.rd_en   (rd_en),
		.raddr_a (raddr_a),
		.raddr_b (raddr_b),
		.rdata_a (rdata_a),
		.rdata_b (rdata_b)
	);

	dqe_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_valid     (q_valid),
		.q_data      (q_data),
		.q_pop       (q_pop),
		.cfg         (cfg_q),
		.rd_en       (rd_en),
		.raddr_a     (raddr_a),
		.raddr_b     (raddr_b),
		.rdata_a     (rdata_a),
		.rdata_b     (rdata_b),
		.store_done  (store_done),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.byte_first  (byte_first),
		.byte_second (byte_second),
		.bytes_valid (bytes_valid),
		.last_of_run (last_of_run),
		.status      (status)
	);

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_push |-> !q_full)
		else $error("command pushed into full queue");

	a_err_beat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && bytes_valid == 2'd0 |-> status && last_of_run)
		else $error("empty beat without error status");

	a_ok_beat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !status |-> bytes_valid != 2'd0)
		else $error("ok beat carries no bytes");

	a_store_write: assert property (@(posedge clk) disable iff (!arst_n)
		store_we |-> in_valid && !in_stall && !cmd_push)
		else $error("label store written outside a character beat");

endmodule

// ===== hw/rtl/dqe_ram.sv =====
`timescale 1ns / 1ps

module dqe_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_a,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		if (rd_en) begin
			rdata_a <= mem_q[raddr_a];
			rdata_b <= mem_q[raddr_b];
		end
	end

endmodule

// ===== hw/rtl/dqe_queue.sv =====
`timescale 1ns / 1ps

module dqe_queue
	import dqe_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_data,
	output logic full,
	input  logic pop,
	output logic valid,
	output cmd_t pop_data
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);

	cmd_t             mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W:0]   cnt_q;
	logic             do_push;
	logic             do_pop;

	assign full     = cnt_q == (PTR_W + 1)'(QUEUE_DEPTH);
	assign valid    = cnt_q != '0;
	assign pop_data = mem_q[rd_ptr_q];
	assign do_push  = push && !full;
	assign do_pop   = pop && valid;

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			if (do_push && !do_pop)
				cnt_q <= cnt_q + (PTR_W + 1)'(1);
			else if (do_pop && !do_push)
				cnt_q <= cnt_q - (PTR_W + 1)'(1);
		end
	end

endmodule

// ===== hw/rtl/dqe_front.sv =====
`timescale 1ns / 1ps

module dqe_front
	import dqe_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [1:0]        req_type,
	input  logic [7:0]        name_char,
	input  logic [15:0]       query_id,
	output logic              cmd_push,
	output cmd_t              cmd_data,
	input  logic              q_full,
	output logic              store_we,
	output logic [ADDR_W-1:0] store_waddr,
	output logic [7:0]        store_wdata,
	input  logic              store_done
);

	phase_t           state_q, state_d;
	logic [CNT_W-1:0] count_q, count_d;
	logic             busy_q;
	logic             busy_set;
	logic             accept;

	assign in_stall    = q_full || busy_q;
	assign accept      = in_valid && !in_stall;
	assign store_waddr = count_q;
	assign store_wdata = name_char;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= PH_IDLE;
			count_q <= '0;
			busy_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			if (busy_set)
				busy_q <= 1'b1;
			else if (store_done)
				busy_q <= 1'b0;
		end
	end

	always_comb begin
		state_d  = state_q;
		count_d  = count_q;
		cmd_push = 1'b0;
		cmd_data = '{kind: CMD_HEADER, has_label: 1'b0, count: count_q, id: query_id};
		store_we = 1'b0;
		busy_set = 1'b0;
		if (accept) begin
			case (req_type)
				REQ_START: begin
					cmd_push = 1'b1;
					count_d  = '0;
					state_d  = PH_OPEN;
				end
				REQ_CHAR: begin
					unique case (state_q)
						PH_OPEN: begin
							if (name_char == DOT_CHAR) begin
								cmd_push      = 1'b1;
								cmd_data.kind = CMD_LABEL;
								busy_set      = 1'b1;
								count_d       = '0;
							end else if (count_q >= CNT_W'(MAX_LABEL)) begin
								cmd_push      = 1'b1;
								cmd_data.kind = CMD_ERROR;
								count_d       = '0;
								state_d       = PH_ABANDONED;
							end else begin
								store_we = 1'b1;
								count_d  = count_q + CNT_W'(1);
							end
						end
						PH_IDLE, PH_ABANDONED: state_d = state_q;
					endcase
				end
				REQ_FINISH: begin
					unique case (state_q)
						PH_OPEN: begin
							cmd_push           = 1'b1;
							cmd_data.kind      = CMD_FINISH;
							cmd_data.has_label = count_q != '0;
							busy_set           = count_q != '0;
							count_d            = '0;
							state_d            = PH_IDLE;
						end
						PH_IDLE, PH_ABANDONED: state_d = state_q;
					endcase
				end
				default: state_d = state_q;
			endcase
		end
	end

endmodule

// ===== hw/rtl/dqe_back.sv =====
`timescale 1ns / 1ps

module dqe_back
	import dqe_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_valid,
	input  cmd_t              q_data,
	output logic              q_pop,
	input  cfg_t              cfg,
	output logic              rd_en,
	output logic [ADDR_W-1:0] raddr_a,
	output logic [ADDR_W-1:0] raddr_b,
	input  logic [7:0]        rdata_a,
	input  logic [7:0]        rdata_b,
	output logic              store_done,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [7:0]        byte_first,
	output logic [7:0]        byte_second,
	output logic [1:0]        bytes_valid,
	output logic              last_of_run,
	output logic              status
);

	logic             cur_valid_q;
	cmd_t             cur_q;
	logic [POS_W-1:0] pos_q;
	logic [POS_W-1:0] len;
	src_t             src_a, src_b;
	logic             is_err, is_last, two;
	logic             s2_free, s1_move, issue;

	logic             valid_s1;
	src_t             src_a_s1, src_b_s1;
	logic             two_s1, last_s1, err_s1;

	logic             out_valid_q;
	logic [7:0]       byte_first_q, byte_second_q;
	logic [1:0]       bytes_valid_q;
	logic             last_q, status_q;

	assign len     = cmd_len(cur_q);
	assign src_a   = byte_src(cur_q, cfg, pos_q);
	assign src_b   = byte_src(cur_q, cfg, pos_q + POS_W'(1));
	assign is_err  = cur_q.kind == CMD_ERROR;
	assign is_last = is_err || ((pos_q + POS_W'(2)) >= len);
	assign two     = !is_err && ((pos_q + POS_W'(1)) < len);

	assign s2_free = !out_valid_q || !out_stall;
	assign s1_move = valid_s1 && s2_free;
	assign issue   = cur_valid_q && (!valid_s1 || s2_free);
	assign q_pop   = !cur_valid_q && q_valid;

	assign rd_en      = issue;
	assign raddr_a    = src_a.addr;
	assign raddr_b    = src_b.addr;
	assign store_done = issue && is_last &&
		(cur_q.kind == CMD_LABEL || (cur_q.kind == CMD_FINISH && cur_q.has_label));

	assign out_valid   = out_valid_q;
	assign byte_first  = byte_first_q;
	assign byte_second = byte_second_q;
	assign bytes_valid = bytes_valid_q;
	assign last_of_run = last_q;
	assign status      = status_q;

	always_ff @(posedge clk) begin
		if (q_pop)
			cur_q <= q_data;
		if (issue) begin
			src_a_s1 <= src_a;
			src_b_s1 <= src_b;
			two_s1   <= two;
			last_s1  <= is_last;
			err_s1   <= is_err;
		end
		if (s1_move) begin
			byte_first_q  <= src_a_s1.is_store ? rdata_a : src_a_s1.value;
			byte_second_q <= two_s1 ? (src_b_s1.is_store ? rdata_b : src_b_s1.value) : 8'h00;
			bytes_valid_q <= err_s1 ? 2'd0 : (two_s1 ? 2'd2 : 2'd1);
			last_q        <= last_s1;
			status_q      <= err_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			pos_q       <= '0;
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				cur_valid_q <= 1'b1;
				pos_q       <= '0;
			end else if (issue) begin
				pos_q <= pos_q + POS_W'(2);
				if (is_last)
					cur_valid_q <= 1'b0;
			end
			if (issue)
				valid_s1 <= 1'b1;
			else if (s1_move)
				valid_s1 <= 1'b0;
			if (s1_move)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

endmodule
